/* hdl/assert_macros.svh */
// assertion macros used by the checker file esm_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ESM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ESM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/esm_pkg.sv */
// types and constants of the euler scale translate matrix block
// no dependencies
package esm_pkg;

  localparam int unsigned ANG_W  = 16;
  localparam int unsigned SCL_W  = 16;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned TRIG_W = 16;
  localparam int unsigned FX_W   = 48;
  localparam int unsigned FX_F   = 47;
  localparam int unsigned N_TERM = 7;

  localparam int unsigned SC_LAT  = 20;
  localparam int unsigned MX_LAT  = 4;
  localparam int unsigned TOT_LAT = SC_LAT + MX_LAT;

  localparam logic [63:0] QONE    = 64'd1 << FX_F;
  localparam logic [63:0] PI_Q47  = 64'h3243F6A8885A308D >> 13;

  // 1/(2k+1)! in Q47
  localparam logic [FX_W-1:0] SIN_COEF [N_TERM+1] = '{
    FX_W'(QONE / 64'd1),
    FX_W'(QONE / 64'd6),
    FX_W'(QONE / 64'd120),
    FX_W'(QONE / 64'd5040),
    FX_W'(QONE / 64'd362880),
    FX_W'(QONE / 64'd39916800),
    FX_W'(QONE / 64'd6227020800),
    FX_W'(QONE / 64'd1307674368000)
  };

  // 1/(2k)! in Q47
  localparam logic [FX_W-1:0] COS_COEF [N_TERM+1] = '{
    FX_W'(QONE / 64'd1),
    FX_W'(QONE / 64'd2),
    FX_W'(QONE / 64'd24),
    FX_W'(QONE / 64'd720),
    FX_W'(QONE / 64'd40320),
    FX_W'(QONE / 64'd3628800),
    FX_W'(QONE / 64'd479001600),
    FX_W'(QONE / 64'd87178291200)
  };

  typedef logic [ANG_W-1:0]         angle_t;
  typedef logic signed [SCL_W-1:0]  scale_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [15:0]       q12_t;
  typedef logic [FX_W-1:0]          fx_t;

  typedef struct packed {
    trig_t sin_v;
    trig_t cos_v;
  } sc_t;

endpackage

/* hdl/esm_mac.sv */
// two-stage unsigned Q47 multiply with add or subtract: p = c +/- a*b
// depends on esm_pkg
module esm_mac (
  input  logic           clk_i,
  input  esm_pkg::fx_t   a_i,
  input  esm_pkg::fx_t   b_i,
  input  esm_pkg::fx_t   c_i,
  input  logic           sub_i,
  output esm_pkg::fx_t   a_o,
  output esm_pkg::fx_t   p_o
);

  localparam int unsigned HW = esm_pkg::FX_W / 2;

  logic [2*HW-1:0]        hh_q, hl_q, lh_q, ll_q;
  esm_pkg::fx_t           c_q, a_q;
  logic                   sub_q;
  logic [4*HW-1:0]        full;
  esm_pkg::fx_t           prod;
  esm_pkg::fx_t           p_d;

  always_ff @(posedge clk_i) begin
    hh_q  <= a_i[2*HW-1:HW] * b_i[2*HW-1:HW];
    hl_q  <= a_i[2*HW-1:HW] * b_i[HW-1:0];
    lh_q  <= a_i[HW-1:0] * b_i[2*HW-1:HW];
    ll_q  <= a_i[HW-1:0] * b_i[HW-1:0];
    c_q   <= c_i;
    a_q   <= a_i;
    sub_q <= sub_i;
  end

  always_comb begin
    full = ({hh_q, {(2*HW){1'b0}}})
         + ((4*HW)'(hl_q) << HW)
         + ((4*HW)'(lh_q) << HW)
         + (4*HW)'(ll_q);
    prod = full[esm_pkg::FX_F +: esm_pkg::FX_W];
    p_d  = sub_q ? (c_q - prod) : (c_q + prod);
  end

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
    a_o <= a_q;
  end

endmodule

/* hdl/esm_sincos.sv */
// pipelined sine and cosine of a binary angle, rounded to Q1.14
// depends on esm_pkg and esm_mac
module esm_sincos (
  input  logic            clk_i,
  input  esm_pkg::angle_t angle_i,
  output esm_pkg::sc_t    sc_o
);

  localparam int unsigned TH_DLY = 2 * esm_pkg::N_TERM;
  localparam int unsigned QS_DLY = TH_DLY + 5;

  logic [13:0]          r, rr;
  logic                 swap;
  esm_pkg::fx_t         th_d, th_q;
  logic [2:0]           qs_q [QS_DLY];
  esm_pkg::fx_t         th_sr_q [TH_DLY];
  esm_pkg::fx_t         x, th3;
  esm_pkg::fx_t         xs [esm_pkg::N_TERM+1];
  esm_pkg::fx_t         sp [esm_pkg::N_TERM+1];
  esm_pkg::fx_t         cp [esm_pkg::N_TERM+1];
  esm_pkg::fx_t         c_sr_q [2];
  esm_pkg::fx_t         s_full;
  logic [14:0]          sv, cv;
  esm_pkg::trig_t       s_m, c_m;
  esm_pkg::sc_t         sc_d;
  logic [1:0]           quad;
  logic                 swp;

  always_comb begin
    r    = angle_i[13:0];
    swap = r > 14'd8192;
    rr   = swap ? 14'(15'd16384 - {1'b0, r}) : r;
    th_d = esm_pkg::FX_W'((64'(rr) * esm_pkg::PI_Q47) >> 15);
  end

  always_ff @(posedge clk_i) begin
    th_q <= th_d;
    qs_q[0] <= {angle_i[15:14], swap};
    for (int i = 1; i < QS_DLY; i++) begin
      qs_q[i] <= qs_q[i-1];
    end
  end

  esm_mac u_sq (
    .clk_i (clk_i), .a_i (th_q), .b_i (th_q), .c_i ('0), .sub_i (1'b0),
    .a_o (th3), .p_o (x)
  );

  assign xs[0] = x;
  assign sp[0] = esm_pkg::SIN_COEF[esm_pkg::N_TERM];
  assign cp[0] = esm_pkg::COS_COEF[esm_pkg::N_TERM];

  for (genvar j = 0; j < esm_pkg::N_TERM; j++) begin : g_term
    esm_mac u_sin (
      .clk_i (clk_i), .a_i (xs[j]), .b_i (sp[j]),
      .c_i (esm_pkg::SIN_COEF[esm_pkg::N_TERM-1-j]), .sub_i (1'b1),
      .a_o (xs[j+1]), .p_o (sp[j+1])
    );
    esm_mac u_cos (
      .clk_i (clk_i), .a_i (xs[j]), .b_i (cp[j]),
      .c_i (esm_pkg::COS_COEF[esm_pkg::N_TERM-1-j]), .sub_i (1'b1),
      .a_o (), .p_o (cp[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    th_sr_q[0] <= th3;
    for (int i = 1; i < TH_DLY; i++) begin
      th_sr_q[i] <= th_sr_q[i-1];
    end
    c_sr_q[0] <= cp[esm_pkg::N_TERM];
    c_sr_q[1] <= c_sr_q[0];
  end

  esm_mac u_fin (
    .clk_i (clk_i), .a_i (th_sr_q[TH_DLY-1]), .b_i (sp[esm_pkg::N_TERM]),
    .c_i ('0), .sub_i (1'b0), .a_o (), .p_o (s_full)
  );

  always_comb begin
    sv   = 15'((s_full + 48'h1_0000_0000) >> 33);
    cv   = 15'((c_sr_q[1] + 48'h1_0000_0000) >> 33);
    quad = qs_q[QS_DLY-1][2:1];
    swp  = qs_q[QS_DLY-1][0];
    s_m  = swp ? esm_pkg::trig_t'({1'b0, cv}) : esm_pkg::trig_t'({1'b0, sv});
    c_m  = swp ? esm_pkg::trig_t'({1'b0, sv}) : esm_pkg::trig_t'({1'b0, cv});
    unique case (quad)
      2'd0: begin
        sc_d.sin_v = s_m;
        sc_d.cos_v = c_m;
      end
      2'd1: begin
        sc_d.sin_v = c_m;
        sc_d.cos_v = -s_m;
      end
      2'd2: begin
        sc_d.sin_v = -s_m;
        sc_d.cos_v = -c_m;
      end
      2'd3: begin
        sc_d.sin_v = -c_m;
        sc_d.cos_v = s_m;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sc_o <= sc_d;
  end

endmodule

/* hdl/esm_matrix.sv */
// four-stage rotation-scale entries: pair products, factors, scale, round
// depends on esm_pkg
module esm_matrix (
  input  logic            clk_i,
  input  esm_pkg::sc_t    scx_i,
  input  esm_pkg::sc_t    scy_i,
  input  esm_pkg::sc_t    scz_i,
  input  esm_pkg::scale_t scale_i [3],
  output esm_pkg::q12_t   m_o [9]
);

  typedef logic signed [31:0] pp_t;
  typedef logic signed [45:0] fac_t;
  typedef logic signed [61:0] prd_t;

  localparam int unsigned W = 14;

  pp_t  cy_cz_q, sy_sx_q, cx_sz_q, cy_sx_q, cz_sy_q;
  pp_t  cy_sz_q, cx_cz_q, sy_sz_q, cx_sy_q, cy_cx_q;
  esm_pkg::trig_t sx_q, sz_q;
  esm_pkg::scale_t scl1_q [3];
  esm_pkg::scale_t scl2_q [3];
  fac_t f_d [9];
  fac_t f_q [9];
  prd_t p_q [9];
  esm_pkg::q12_t m_d [9];

  always_ff @(posedge clk_i) begin
    cy_cz_q <= scy_i.cos_v * scz_i.cos_v;
    sy_sx_q <= scy_i.sin_v * scx_i.sin_v;
    cx_sz_q <= scx_i.cos_v * scz_i.sin_v;
    cy_sx_q <= scy_i.cos_v * scx_i.sin_v;
    cz_sy_q <= scz_i.cos_v * scy_i.sin_v;
    cy_sz_q <= scy_i.cos_v * scz_i.sin_v;
    cx_cz_q <= scx_i.cos_v * scz_i.cos_v;
    sy_sz_q <= scy_i.sin_v * scz_i.sin_v;
    cx_sy_q <= scx_i.cos_v * scy_i.sin_v;
    cy_cx_q <= scy_i.cos_v * scx_i.cos_v;
    sx_q    <= scx_i.sin_v;
    sz_q    <= scz_i.sin_v;
    scl1_q  <= scale_i;
  end

  always_comb begin
    f_d[0] = (fac_t'(cy_cz_q) <<< W) + fac_t'(sy_sx_q) * sz_q;
    f_d[1] = fac_t'(cx_sz_q) <<< W;
    f_d[2] = fac_t'(cy_sx_q) * sz_q - (fac_t'(cz_sy_q) <<< W);
    f_d[3] = fac_t'(cz_sy_q) * sx_q - (fac_t'(cy_sz_q) <<< W);
    f_d[4] = fac_t'(cx_cz_q) <<< W;
    f_d[5] = fac_t'(cy_cz_q) * sx_q + (fac_t'(sy_sz_q) <<< W);
    f_d[6] = fac_t'(cx_sy_q) <<< W;
    f_d[7] = -(fac_t'(sx_q) <<< (2 * W));
    f_d[8] = fac_t'(cy_cx_q) <<< W;
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    scl2_q <= scl1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      p_q[i] <= scl2_q[i/3] * f_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      logic signed [19:0] t;
      t = 20'((p_q[i] + (prd_t'(1) <<< 41)) >>> 42);
      if (t < -20'sd32768) begin
        m_d[i] = 16'sh8000;
      end else if (t > 20'sd32767) begin
        m_d[i] = 16'sh7FFF;
      end else begin
        m_d[i] = 16'(t);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_o <= m_d;
  end

endmodule

/* hdl/euler_scale_translate_matrix.sv */
// the result strobe done_o is the request passed down the valid shift register vld_q
// throughput: one request per cycle; busy stays low, the pipeline never stalls
// the depth is set by the sine/cosine Horner chain, one esm_mac per series term
// reset clears the valid bits only; results in flight at reset are dropped
// top level of the euler scale translate matrix; depends on esm_pkg,
// esm_sincos, esm_matrix
module euler_scale_translate_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  esm_pkg::angle_t angle_x_i,
  input  esm_pkg::angle_t angle_y_i,
  input  esm_pkg::angle_t angle_z_i,
  input  esm_pkg::scale_t scale_x_i,
  input  esm_pkg::scale_t scale_y_i,
  input  esm_pkg::scale_t scale_z_i,
  input  esm_pkg::pos_t   pos_x_i,
  input  esm_pkg::pos_t   pos_y_i,
  input  esm_pkg::pos_t   pos_z_i,
  output logic            done_o,
  output esm_pkg::q12_t   m00_o,
  output esm_pkg::q12_t   m01_o,
  output esm_pkg::q12_t   m02_o,
  output esm_pkg::q12_t   m10_o,
  output esm_pkg::q12_t   m11_o,
  output esm_pkg::q12_t   m12_o,
  output esm_pkg::q12_t   m20_o,
  output esm_pkg::q12_t   m21_o,
  output esm_pkg::q12_t   m22_o,
  output esm_pkg::pos_t   t_x_o,
  output esm_pkg::pos_t   t_y_o,
  output esm_pkg::pos_t   t_z_o
);

  localparam int unsigned SL = esm_pkg::SC_LAT;
  localparam int unsigned TL = esm_pkg::TOT_LAT;

  logic            vld_q [TL+1];
  esm_pkg::angle_t ang_q [3];
  esm_pkg::scale_t scl_q [SL+1][3];
  esm_pkg::pos_t   pos_q [TL+1][3];
  esm_pkg::sc_t    sc [3];
  esm_pkg::q12_t   m [9];
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TL; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i <= TL; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q       <= '{angle_x_i, angle_y_i, angle_z_i};
    scl_q[0]    <= '{scale_x_i, scale_y_i, scale_z_i};
    pos_q[0]    <= '{pos_x_i, pos_y_i, pos_z_i};
    for (int i = 1; i <= SL; i++) begin
      scl_q[i] <= scl_q[i-1];
    end
    for (int i = 1; i <= TL; i++) begin
      pos_q[i] <= pos_q[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    esm_sincos u_sc (
      .clk_i   (clk_i),
      .angle_i (ang_q[k]),
      .sc_o    (sc[k])
    );
  end

  esm_matrix u_mx (
    .clk_i   (clk_i),
    .scx_i   (sc[0]),
    .scy_i   (sc[1]),
    .scz_i   (sc[2]),
    .scale_i (scl_q[SL]),
    .m_o     (m)
  );

  assign done_o = vld_q[TL];
  assign m00_o  = m[0];
  assign m01_o  = m[1];
  assign m02_o  = m[2];
  assign m10_o  = m[3];
  assign m11_o  = m[4];
  assign m12_o  = m[5];
  assign m20_o  = m[6];
  assign m21_o  = m[7];
  assign m22_o  = m[8];
  assign t_x_o  = pos_q[TL][0];
  assign t_y_o  = pos_q[TL][1];
  assign t_z_o  = pos_q[TL][2];

endmodule

/* hdl/esm_checker.sv */
// port-level checks of the euler scale translate matrix, bound to the top level
// depends on esm_pkg and assert_macros.svh
`include "assert_macros.svh"

module esm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input esm_pkg::scale_t scale_z_i,
  input esm_pkg::pos_t   pos_x_i,
  input esm_pkg::pos_t   pos_y_i,
  input esm_pkg::q12_t   m21_o,
  input esm_pkg::pos_t   t_x_o,
  input esm_pkg::pos_t   t_y_o
);

  `ESM_ASSERT_ALWAYS(a_never_busy, clk_i, !busy, "busy raised")
  `ESM_ASSERT(a_done_has_req, clk_i, rst_ni, done_o |-> $past(start && !busy, 25), "result without request")
  `ESM_ASSERT(a_tx_pass, clk_i, rst_ni, done_o |-> (t_x_o == $past(pos_x_i, 25)) && (t_y_o == $past(pos_y_i, 25)), "translation mismatch")
  `ESM_ASSERT(a_zero_scale, clk_i, rst_ni, (done_o && $past(scale_z_i == 16'sd0, 25)) |-> (m21_o == 16'sd0), "zero scale gave nonzero entry")

endmodule

bind euler_scale_translate_matrix esm_checker u_esm_chk (.*);
